### rtl/psd_pkg.sv
// Package: shared types, widths and codes for the point to segment distance block.
`timescale 1ns / 1ps
package psd_pkg;

	localparam int COORD_BITS = 24;
	localparam int VEC_BITS   = COORD_BITS + 1;
	localparam int FRAC_BITS  = 8;
	localparam int DIST_BITS  = 34;
	localparam int ADDR_BITS  = 5;

	// Widths of the intermediate values
	localparam int LEN2_BITS  = 51;
	localparam int QUO_BITS   = 51;
	localparam int D2_BITS    = 52;
	localparam int SQ_BITS    = 2 * QUO_BITS;
	localparam int SQ_STEPS   = D2_BITS / 2 + FRAC_BITS;
	localparam int RAD_BITS   = 2 * SQ_STEPS;
	localparam int REM_BITS   = SQ_STEPS + 2;

	typedef enum logic [1:0] {
		REGION_INTERIOR   = 2'd0,
		REGION_END_A      = 2'd1,
		REGION_END_B      = 2'd2,
		REGION_DEGENERATE = 2'd3
	} psd_region_t;

	typedef enum logic [2:0] {
		REG_END_A_X   = 3'd0,
		REG_END_A_Y   = 3'd1,
		REG_END_A_Z   = 3'd2,
		REG_SEG_VEC_X = 3'd3,
		REG_SEG_VEC_Y = 3'd4,
		REG_SEG_VEC_Z = 3'd5
	} psd_reg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] point_x;
		logic signed [COORD_BITS-1:0] point_y;
		logic signed [COORD_BITS-1:0] point_z;
	} psd_in_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance_q8;
		logic [1:0]           nearest_region;
	} psd_out_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] a_x;
		logic signed [COORD_BITS-1:0] a_y;
		logic signed [COORD_BITS-1:0] a_z;
		logic signed [VEC_BITS-1:0]   v_x;
		logic signed [VEC_BITS-1:0]   v_y;
		logic signed [VEC_BITS-1:0]   v_z;
		logic [LEN2_BITS-1:0]         len2;
	} psd_cfg_t;

	// One request as it moves along the divider cells
	typedef struct packed {
		logic [QUO_BITS-1:0] rem;
		logic [QUO_BITS-1:0] num;
		logic [QUO_BITS-1:0] quo;
		logic [D2_BITS-1:0]  base;
		psd_region_t         region;
	} psd_div_t;

	// One request as it moves along the square root cells
	typedef struct packed {
		logic [RAD_BITS-1:0] rad;
		logic [SQ_STEPS-1:0] root;
		logic [REM_BITS-1:0] rem;
		psd_region_t         region;
	} psd_sqrt_t;

endpackage

### rtl/psd_cfg.sv
// Configuration registers with APB-style access and the squared segment length.
`timescale 1ns / 1ps
module psd_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [psd_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output psd_pkg::psd_cfg_t          cfg
);
	import psd_pkg::*;

	logic signed [COORD_BITS-1:0] a_x_q, a_y_q, a_z_q;
	logic signed [VEC_BITS-1:0]   v_x_q, v_y_q, v_z_q;
	logic [LEN2_BITS-1:0]         len2_q;
	logic                         wr_en;
	psd_reg_t                     idx;
	logic signed [2*VEC_BITS-1:0] px, py, pz;

	assign wr_en = psel & penable & pwrite;
	assign idx   = psd_reg_t'(paddr[4:2]);

	// Write the addressed register; ignore addresses beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_x_q <= '0;
			a_y_q <= '0;
			a_z_q <= '0;
			v_x_q <= '0;
			v_y_q <= '0;
			v_z_q <= '0;
		end else if (wr_en) begin
			unique case (idx)
				REG_END_A_X:   a_x_q <= pwdata[COORD_BITS-1:0];
				REG_END_A_Y:   a_y_q <= pwdata[COORD_BITS-1:0];
				REG_END_A_Z:   a_z_q <= pwdata[COORD_BITS-1:0];
				REG_SEG_VEC_X: v_x_q <= pwdata[VEC_BITS-1:0];
				REG_SEG_VEC_Y: v_y_q <= pwdata[VEC_BITS-1:0];
				REG_SEG_VEC_Z: v_z_q <= pwdata[VEC_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Read back the raw register bits
	always_comb begin
		unique case (idx)
			REG_END_A_X:   prdata = {{(32-COORD_BITS){1'b0}}, a_x_q};
			REG_END_A_Y:   prdata = {{(32-COORD_BITS){1'b0}}, a_y_q};
			REG_END_A_Z:   prdata = {{(32-COORD_BITS){1'b0}}, a_z_q};
			REG_SEG_VEC_X: prdata = {{(32-VEC_BITS){1'b0}}, v_x_q};
			REG_SEG_VEC_Y: prdata = {{(32-VEC_BITS){1'b0}}, v_y_q};
			REG_SEG_VEC_Z: prdata = {{(32-VEC_BITS){1'b0}}, v_z_q};
			default:       prdata = '0;
		endcase
	end

	// Track the squared length of the segment vector
	assign px = v_x_q * v_x_q;
	assign py = v_y_q * v_y_q;
	assign pz = v_z_q * v_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len2_q <= '0;
		end else begin
			len2_q <= LEN2_BITS'(px) + LEN2_BITS'(py) + LEN2_BITS'(pz);
		end
	end

	assign cfg = '{a_x: a_x_q, a_y: a_y_q, a_z: a_z_q,
		v_x: v_x_q, v_y: v_y_q, v_z: v_z_q, len2: len2_q};

endmodule

### rtl/psd_front.sv
// Front pipeline: offsets, dot products, region choice and the squared projection.
`timescale 1ns / 1ps
module psd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                adv,
	input  logic                in_valid,
	input  psd_pkg::psd_in_t    in_data,
	input  psd_pkg::psd_cfg_t   cfg,
	output logic                out_valid,
	output psd_pkg::psd_div_t   out_data
);
	import psd_pkg::*;

	logic [6:1] valid_q;

	logic signed [VEC_BITS-1:0]     zx_s1, zy_s1, zz_s1;
	logic signed [VEC_BITS:0]       bx, by, bz;
	logic signed [2*VEC_BITS-1:0]   zxx_s2, zyy_s2, zzz_s2;
	logic signed [2*VEC_BITS-1:0]   dx_s2, dy_s2, dz_s2;
	logic signed [2*VEC_BITS+1:0]   bxx_s2, byy_s2, bzz_s2;
	logic signed [D2_BITS-1:0]      az2_s3, dot_s3;
	logic signed [D2_BITS+1:0]      b2_s3;
	logic [D2_BITS-1:0]             base_s4, base_s5, base_s6;
	logic [QUO_BITS-1:0]            dmag_s4;
	psd_region_t                    region_s4, region_s5, region_s6;
	logic [51:0]                    hh_s5;
	logic [50:0]                    hl_s5;
	logic [49:0]                    ll_s5;
	logic [SQ_BITS-1:0]             sq_s6;
	logic signed [D2_BITS-1:0]      len2_s;

	assign len2_s = $signed({1'b0, cfg.len2});

	// Track valid through the stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (adv) begin
			valid_q <= {valid_q[5:1], in_valid};
		end
	end

	assign bx = {zx_s1[VEC_BITS-1], zx_s1} - {cfg.v_x[VEC_BITS-1], cfg.v_x};
	assign by = {zy_s1[VEC_BITS-1], zy_s1} - {cfg.v_y[VEC_BITS-1], cfg.v_y};
	assign bz = {zz_s1[VEC_BITS-1], zz_s1} - {cfg.v_z[VEC_BITS-1], cfg.v_z};

	// Advance the payload stages
	always_ff @(posedge clk) begin
		if (adv) begin
			// Offset from A
			zx_s1 <= {in_data.point_x[COORD_BITS-1], in_data.point_x}
				- {cfg.a_x[COORD_BITS-1], cfg.a_x};
			zy_s1 <= {in_data.point_y[COORD_BITS-1], in_data.point_y}
				- {cfg.a_y[COORD_BITS-1], cfg.a_y};
			zz_s1 <= {in_data.point_z[COORD_BITS-1], in_data.point_z}
				- {cfg.a_z[COORD_BITS-1], cfg.a_z};

			// Products
			zxx_s2 <= zx_s1 * zx_s1;
			zyy_s2 <= zy_s1 * zy_s1;
			zzz_s2 <= zz_s1 * zz_s1;
			dx_s2  <= cfg.v_x * zx_s1;
			dy_s2  <= cfg.v_y * zy_s1;
			dz_s2  <= cfg.v_z * zz_s1;
			bxx_s2 <= bx * bx;
			byy_s2 <= by * by;
			bzz_s2 <= bz * bz;

			// Sums
			az2_s3 <= D2_BITS'(zxx_s2) + D2_BITS'(zyy_s2) + D2_BITS'(zzz_s2);
			dot_s3 <= D2_BITS'(dx_s2) + D2_BITS'(dy_s2) + D2_BITS'(dz_s2);
			b2_s3  <= (D2_BITS+2)'(bxx_s2) + (D2_BITS+2)'(byy_s2) + (D2_BITS+2)'(bzz_s2);

			// Pick the nearest part of the segment
			if (cfg.len2 == '0) begin
				region_s4 <= REGION_DEGENERATE;
				base_s4   <= az2_s3;
				dmag_s4   <= '0;
			end else if (dot_s3 < 0) begin
				region_s4 <= REGION_END_A;
				base_s4   <= az2_s3;
				dmag_s4   <= '0;
			end else if (dot_s3 > len2_s) begin
				region_s4 <= REGION_END_B;
				base_s4   <= b2_s3[D2_BITS-1:0];
				dmag_s4   <= '0;
			end else begin
				region_s4 <= REGION_INTERIOR;
				base_s4   <= az2_s3;
				dmag_s4   <= dot_s3[QUO_BITS-1:0];
			end

			// Partial products of the squared projection
			hh_s5     <= dmag_s4[50:25] * dmag_s4[50:25];
			hl_s5     <= dmag_s4[50:25] * dmag_s4[24:0];
			ll_s5     <= dmag_s4[24:0] * dmag_s4[24:0];
			base_s5   <= base_s4;
			region_s5 <= region_s4;

			// Combine the partial products
			sq_s6     <= ({50'd0, hh_s5} << 50) + ({51'd0, hl_s5} << 26) + {52'd0, ll_s5};
			base_s6   <= base_s5;
			region_s6 <= region_s5;
		end
	end

	assign out_valid = valid_q[6];
	assign out_data  = '{rem: sq_s6[SQ_BITS-1:QUO_BITS], num: sq_s6[QUO_BITS-1:0],
		quo: '0, base: base_s6, region: region_s6};

endmodule

### rtl/psd_div_cell.sv
// Divider cell: one restoring quotient bit per cell.
`timescale 1ns / 1ps
module psd_div_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        adv,
	input  logic [psd_pkg::LEN2_BITS-1:0] divisor,
	input  logic                        in_valid,
	input  psd_pkg::psd_div_t           in_data,
	output logic                        out_valid,
	output psd_pkg::psd_div_t           out_data
);
	import psd_pkg::*;

	logic                valid_q;
	psd_div_t            data_q;
	logic [QUO_BITS:0]   trial;
	logic [QUO_BITS:0]   diff;
	psd_div_t            nxt;

	// Shift in the next numerator bit and try a subtract
	always_comb begin
		trial = {in_data.rem, in_data.num[QUO_BITS-1]};
		diff  = trial - {1'b0, divisor};
		nxt   = in_data;
		nxt.num = {in_data.num[QUO_BITS-2:0], 1'b0};
		if (trial >= {1'b0, divisor}) begin
			nxt.rem = diff[QUO_BITS-1:0];
			nxt.quo = {in_data.quo[QUO_BITS-2:0], 1'b1};
		end else begin
			nxt.rem = trial[QUO_BITS-1:0];
			nxt.quo = {in_data.quo[QUO_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### rtl/psd_sqrt_cell.sv
// Square root cell: one root bit per cell from two radicand bits.
`timescale 1ns / 1ps
module psd_sqrt_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  logic                 in_valid,
	input  psd_pkg::psd_sqrt_t   in_data,
	output logic                 out_valid,
	output psd_pkg::psd_sqrt_t   out_data
);
	import psd_pkg::*;

	logic                valid_q;
	psd_sqrt_t           data_q;
	logic [REM_BITS-1:0] part;
	logic [REM_BITS-1:0] trial;
	psd_sqrt_t           nxt;

	// Bring down two bits and test the next root bit
	always_comb begin
		part  = {in_data.rem[REM_BITS-3:0], in_data.rad[RAD_BITS-1 -: 2]};
		trial = {in_data.root, 2'b01};
		nxt   = in_data;
		nxt.rad = {in_data.rad[RAD_BITS-3:0], 2'b00};
		if (part >= trial) begin
			nxt.rem  = part - trial;
			nxt.root = {in_data.root[SQ_STEPS-2:0], 1'b1};
		end else begin
			nxt.rem  = part;
			nxt.root = {in_data.root[SQ_STEPS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### rtl/point_segment_distance_3d_top.sv
// Top level: distance from a point to a fixed 3D segment, fully pipelined.
//
//  channel   | handshake              | payload
//  ----------+------------------------+--------------------------------------
//  point     | point_valid/point_stall| point_x, point_y, point_z
//  dist      | dist_valid/dist_stall  | distance_q8, nearest_region
//  config    | psel/penable/pwrite    | paddr, pwdata, prdata, pready
//
//  One request enters per cycle unless a result is stalled; a request passes the
//  front stages, 51 divider cells, d2_q, 34 square root cells, output register.
//  Reset clears the config registers and all valid flags; there is no clearing pass.
//  A stall on a waiting result holds the whole pipeline and stalls the input.
`timescale 1ns / 1ps
module point_segment_distance_3d_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [psd_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          point_valid,
	output logic                          point_stall,
	input  psd_pkg::psd_in_t              point,
	output logic                          dist_valid,
	input  logic                          dist_stall,
	output psd_pkg::psd_out_t             dist_data
);
	import psd_pkg::*;

	psd_cfg_t   cfg;
	logic       adv;
	logic       div_valid [QUO_BITS+1];
	psd_div_t   div_data  [QUO_BITS+1];
	logic       sq_valid  [SQ_STEPS+1];
	psd_sqrt_t  sq_data   [SQ_STEPS+1];
	logic       d2_valid_q;
	logic [D2_BITS-1:0] d2_q;
	psd_region_t region_q;
	logic signed [D2_BITS:0] diff;
	logic       out_valid_q;
	psd_out_t   out_q;

	// Move everything on unless a finished result is held up
	assign adv         = !out_valid_q || !dist_stall;
	assign point_stall = !adv;
	assign pready      = 1'b1;

	psd_cfg u_cfg (
		.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
	);

	psd_front u_front (
		.clk, .arst_n, .adv,
		.in_valid  (point_valid),
		.in_data   (point),
		.cfg,
		.out_valid (div_valid[0]),
		.out_data  (div_data[0])
	);

	// Divider chain
	for (genvar i = 0; i < QUO_BITS; i++) begin : g_div
		psd_div_cell u_cell (
			.clk, .arst_n, .adv,
			.divisor   (cfg.len2),
			.in_valid  (div_valid[i]),
			.in_data   (div_data[i]),
			.out_valid (div_valid[i+1]),
			.out_data  (div_data[i+1])
		);
	end

	// Subtract the projection and clamp at zero
	assign diff = $signed({1'b0, div_data[QUO_BITS].base})
		- $signed({2'b00, (div_data[QUO_BITS].region == REGION_INTERIOR)
			? div_data[QUO_BITS].quo : {QUO_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d2_valid_q <= 1'b0;
		end else if (adv) begin
			d2_valid_q <= div_valid[QUO_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d2_q     <= diff[D2_BITS] ? '0 : diff[D2_BITS-1:0];
			region_q <= div_data[QUO_BITS].region;
		end
	end

	assign sq_valid[0] = d2_valid_q;
	assign sq_data[0]  = '{rad: {d2_q, {(2*FRAC_BITS){1'b0}}}, root: '0, rem: '0,
		region: region_q};

	// Square root chain
	for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
		psd_sqrt_cell u_cell (
			.clk, .arst_n, .adv,
			.in_valid  (sq_valid[j]),
			.in_data   (sq_data[j]),
			.out_valid (sq_valid[j+1]),
			.out_data  (sq_data[j+1])
		);
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= sq_valid[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q.distance_q8    <= DIST_BITS'(sq_data[SQ_STEPS].root);
			out_q.nearest_region <= sq_data[SQ_STEPS].region;
		end
	end

	assign dist_valid = out_valid_q;
	assign dist_data  = out_q;

endmodule

### tb/sv/tb.sv
// Testbench: random and directed point queries against several 3D segments, checked in order.
`timescale 1ns / 1ps
module tb;
	import psd_pkg::*;

	localparam int LATENCY    = 93;
	localparam int IDLE_LIMIT = 4000;

	logic                 clk;
	logic                 arst_n;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [ADDR_BITS-1:0] paddr;
	logic [31:0]          pwdata;
	logic [31:0]          prdata;
	logic                 pready;
	logic                 point_valid;
	logic                 point_stall;
	psd_in_t              point;
	logic                 dist_valid;
	logic                 dist_stall;
	psd_out_t             dist_data;

	point_segment_distance_3d_top dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.point_valid(point_valid), .point_stall(point_stall), .point(point),
		.dist_valid(dist_valid), .dist_stall(dist_stall), .dist_data(dist_data)
	);

	// Segment settings held by the predictor
	logic signed [COORD_BITS-1:0] seg_a [3];
	logic signed [VEC_BITS-1:0]   seg_v [3];

	psd_in_t  pending_points[$];
	psd_out_t expected_dists[$];
	int       errors;
	int       idle_cycles;
	bit       calm;
	bit       hold_points;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Floor square root of a nonnegative integer, for roots below 2**46
	function automatic logic [63:0] isqrt(input logic [127:0] n);
		logic [63:0]  r;
		logic [63:0]  c;
		r = '0;
		for (int b = 45; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if (128'(c) * 128'(c) <= n)
				r = c;
		end
		return r;
	endfunction

	// Distance and nearest part of the segment for one point
	function automatic psd_out_t segment_distance(input psd_in_t p);
		logic signed [63:0] zx, zy, zz, vx, vy, vz, az2, len2, dotp, d2, bx, by, bz;
		logic [127:0]       sq;
		psd_out_t           r;
		zx = 64'(p.point_x) - 64'(seg_a[0]);
		zy = 64'(p.point_y) - 64'(seg_a[1]);
		zz = 64'(p.point_z) - 64'(seg_a[2]);
		vx = 64'(seg_v[0]);
		vy = 64'(seg_v[1]);
		vz = 64'(seg_v[2]);
		az2  = zx * zx + zy * zy + zz * zz;
		len2 = vx * vx + vy * vy + vz * vz;
		dotp = vx * zx + vy * zy + vz * zz;
		if (len2 == 0) begin
			d2 = az2;
			r.nearest_region = REGION_DEGENERATE;
		end else if (dotp < 0) begin
			d2 = az2;
			r.nearest_region = REGION_END_A;
		end else if (dotp > len2) begin
			bx = zx - vx;
			by = zy - vy;
			bz = zz - vz;
			d2 = bx * bx + by * by + bz * bz;
			r.nearest_region = REGION_END_B;
		end else begin
			sq = (128'(dotp) * 128'(dotp)) / 128'(len2);
			d2 = az2 - 64'(sq);
			r.nearest_region = REGION_INTERIOR;
		end
		if (d2 < 0)
			d2 = 0;
		r.distance_q8 = DIST_BITS'(isqrt(128'(d2) << (2 * FRAC_BITS)));
		return r;
	endfunction

	task automatic write_reg(input psd_reg_t idx, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_BITS'(4 * int'(idx));
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx <= REG_END_A_Z)
			seg_a[int'(idx)] = val[COORD_BITS-1:0];
		else
			seg_v[int'(idx) - 3] = val[VEC_BITS-1:0];
	endtask

	task automatic set_segment(input logic [31:0] ax, ay, az, vx, vy, vz);
		write_reg(REG_END_A_X, ax);
		write_reg(REG_END_A_Y, ay);
		write_reg(REG_END_A_Z, az);
		write_reg(REG_SEG_VEC_X, vx);
		write_reg(REG_SEG_VEC_Y, vy);
		write_reg(REG_SEG_VEC_Z, vz);
	endtask

	// Wait for the pipeline to drain before touching the registers
	task automatic drain();
		wait (pending_points.size() == 0 && !point_valid && expected_dists.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [23:0] rnd_coord(input int mode);
		case (mode)
			0:       return 24'($urandom);
			1:       return 24'($signed(24'($urandom_range(0, 2000))) - 1000);
			default: return ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
		endcase
	endfunction

	function automatic psd_in_t make_point(input int mode);
		psd_in_t p;
		p.point_x = rnd_coord(mode);
		p.point_y = rnd_coord(mode);
		p.point_z = rnd_coord(mode);
		return p;
	endfunction

	task automatic push_point(input logic [23:0] x, y, z);
		psd_in_t p;
		p.point_x = x;
		p.point_y = y;
		p.point_z = z;
		pending_points.push_back(p);
	endtask

	// Stimulus: reset, directed points, random phases over several segments
	initial begin
		int m;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		point_valid = 1'b0; point = '0; dist_stall = 1'b0;
		errors = 0; calm = 1'b0; hold_points = 1'b0;
		for (int i = 0; i < 3; i++) begin
			seg_a[i] = '0;
			seg_v[i] = '0;
		end
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		// degenerate segment at reset
		push_point(24'd0, 24'd0, 24'd0);
		push_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		push_point(24'h800000, 24'h800000, 24'h800000);
		drain();
		// along x from 0 to 100: both ends, exact projections, interior
		set_segment(0, 0, 0, 100, 0, 0);
		push_point(24'd0, 24'd5, 24'd0);
		push_point(24'd100, 24'd0, 24'd7);
		push_point(24'd50, 24'd3, 24'd4);
		push_point(-24'sd20, 24'd0, 24'd0);
		push_point(24'd130, 24'd40, 24'd0);
		push_point(24'd1, 24'd1, 24'd1);
		drain();
		// extremes of every register
		set_segment(32'h800000, 32'h7FFFFF, 32'h800000, 32'h0FFFFFF, 32'h1000000, 32'h0FFFFFF);
		push_point(24'h7FFFFF, 24'h800000, 24'h7FFFFF);
		push_point(24'h800000, 24'h7FFFFF, 24'h800000);
		push_point(24'd0, 24'd0, 24'd0);
		push_point(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
		drain();
		set_segment(32'h7FFFFF, 32'h800000, 32'h7FFFFF, 32'h1000000, 32'h0FFFFFF, 32'h1000000);
		push_point(24'h800000, 24'h7FFFFF, 24'h800000);
		push_point(24'h7FFFFF, 24'h7FFFFF, 24'h800000);
		push_point(24'd0, 24'd0, 24'd0);
		drain();
		// random segments, a long calm stretch in the second phase
		for (int ph = 0; ph < 7; ph++) begin
			m = ph % 3;
			if (ph == 5)
				set_segment(0, 0, 0, 0, 0, 0);
			else if (m == 1)
				set_segment($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200,
					$urandom_range(0, 400) - 200, $urandom_range(0, 1200) - 600,
					$urandom_range(0, 1200) - 600, $urandom_range(0, 1200) - 600);
			else
				set_segment($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			calm = (ph == 1);
			for (int i = 0; i < 200; i++) begin
				pending_points.push_back(make_point(($urandom_range(0, 9) == 0) ? 2 : m % 2));
				// pause the sender once until the pipeline has emptied
				if (ph == 3 && i == 100) begin
					wait (pending_points.size() == 0);
					hold_points = 1'b1;
					wait (!point_valid && expected_dists.size() == 0);
					hold_points = 1'b0;
				end
			end
			calm = 1'b0;
			drain();
		end
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// Drive points from the pending queue
	always @(posedge clk) begin
		if (arst_n) begin
			if (!point_valid || !point_stall) begin
				if (point_valid)
					expected_dists.push_back(segment_distance(point));
				if (pending_points.size() > 0 && !hold_points
						&& (calm || $urandom_range(0, 99) >= 13)) begin
					point_valid <= 1'b1;
					point       <= pending_points.pop_front();
				end else begin
					point_valid <= 1'b0;
				end
			end
		end
	end

	// Check results and stall the output at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (dist_valid && !dist_stall) begin
				if (expected_dists.size() == 0) begin
					$error("result with nothing expected: %0d", dist_data.distance_q8);
					errors++;
				end else begin
					psd_out_t e;
					e = expected_dists.pop_front();
					if (dist_data.distance_q8 !== e.distance_q8) begin
						$error("distance_q8: expected %0d, got %0d", e.distance_q8,
							dist_data.distance_q8);
						errors++;
					end
					if (dist_data.nearest_region !== e.nearest_region) begin
						$error("nearest_region: expected %0d, got %0d", e.nearest_region,
							dist_data.nearest_region);
						errors++;
					end
				end
			end
			dist_stall <= !calm && ($urandom_range(0, 99) < 13);
		end
	end

	// Watchdog on cycles without any accepted request
	always @(posedge clk) begin
		if (!arst_n || (point_valid && !point_stall) || (dist_valid && !dist_stall)
				|| psel)
			idle_cycles <= 0;
		else if (pending_points.size() == 0 && expected_dists.size() == 0)
			idle_cycles <= 0;
		else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule

### point_segment_distance_3d_top.f
rtl/psd_pkg.sv
rtl/psd_cfg.sv
rtl/psd_front.sv
rtl/psd_div_cell.sv
rtl/psd_sqrt_cell.sv
rtl/point_segment_distance_3d_top.sv
tb/sv/tb.sv
